// ===== rtl/sjse_pkg.sv =====
// sjse_pkg: shared constants, types and helpers for the sjis string literal escaper
// no dependencies; sjse_front, sjse_queue, sjse_back and the top refer to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package sjse_pkg;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;

  localparam int unsigned MAX_RUN = 4;
  localparam int unsigned RUN_IDX_W = $clog2(MAX_RUN);
  localparam int unsigned RUN_CNT_W = $clog2(MAX_RUN + 1);

  // one item's worth of output bytes, first byte in slot 0
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [RUN_IDX_W-1:0]    last_idx;
    logic                    done;
  } cmd_t;

  function automatic logic is_lead(input logic [7:0] c);
    is_lead = (c inside {[8'h81:8'h9F]}) || (c inside {[8'hE0:8'hFC]});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sjse_in_if.sv =====
// sjse_in_if: input channel carrying one source byte or a terminator per item
// valid/ready handshake; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sjse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== rtl/sjse_out_if.sv =====
// sjse_out_if: output channel carrying one byte of the quoted literal per item
// valid/ready handshake; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sjse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_in_run;
  logic       literal_done;

  modport source (output valid, output out_byte, output last_in_run, output literal_done,
                  input ready);
  modport sink   (input valid, input out_byte, input last_in_run, input literal_done,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/sjse_front.sv =====
// sjse_front: accepts input items, tracks quote/cr/trail state, builds at most one command per item
// depends on sjse_pkg and sjse_in_if
`timescale 1ns / 1ps
`default_nettype none

module sjse_front (
  input  wire logic          clk,
  input  wire logic          rst,
  sjse_in_if.sink            in_ch,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  output sjse_pkg::cmd_t     push_cmd,
  output logic               push_valid,
  input  wire logic          push_ready
);

  logic multibyte_enable;
  logic quote_open;
  logic pending_cr;
  logic trail_pending;
  logic quote_open_next;
  logic pending_cr_next;
  logic trail_pending_next;

  logic [sjse_pkg::RUN_CNT_W-1:0]            n;
  logic [sjse_pkg::MAX_RUN-1:0][7:0]         bytes;
  logic                                      done;
  logic                                      handled;
  logic [7:0]                                c;
  logic                                      accept;

  assign c = in_ch.char_byte;

  always_comb begin
    n = '0;
    bytes = '0;
    done = 1'b0;
    handled = 1'b0;
    quote_open_next = quote_open;
    pending_cr_next = pending_cr;
    trail_pending_next = trail_pending;
    if (!quote_open) begin
      bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = sjse_pkg::CH_QUOTE;
      n = n + 1'b1;
      quote_open_next = 1'b1;
    end
    if (in_ch.end_of_string) begin
      if (pending_cr) begin
        bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = sjse_pkg::CH_BSLASH;
        n = n + 1'b1;
        bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = sjse_pkg::CH_LOW_R;
        n = n + 1'b1;
      end
      bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = sjse_pkg::CH_QUOTE;
      n = n + 1'b1;
      done = 1'b1;
      quote_open_next = 1'b0;
      pending_cr_next = 1'b0;
      trail_pending_next = 1'b0;
    end else if (trail_pending) begin
      bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = c;
      n = n + 1'b1;
      trail_pending_next = 1'b0;
    end else begin
      if (pending_cr) begin
        pending_cr_next = 1'b0;
        bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = sjse_pkg::CH_BSLASH;
        n = n + 1'b1;
        if (c == sjse_pkg::CH_LF) begin
          bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = sjse_pkg::CH_LOW_N;
          handled = 1'b1;
        end else begin
          bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = sjse_pkg::CH_LOW_R;
        end
        n = n + 1'b1;
      end
      if (!handled) begin
        if (c == sjse_pkg::CH_CR) begin
          pending_cr_next = 1'b1;
        end else if (c == sjse_pkg::CH_TAB || c == sjse_pkg::CH_QUOTE ||
                     c == sjse_pkg::CH_BSLASH) begin
          bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = sjse_pkg::CH_BSLASH;
          n = n + 1'b1;
          bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = (c == sjse_pkg::CH_TAB) ?
                                               sjse_pkg::CH_LOW_T : c;
          n = n + 1'b1;
        end else begin
          bytes[n[sjse_pkg::RUN_IDX_W-1:0]] = c;
          n = n + 1'b1;
          if (multibyte_enable && sjse_pkg::is_lead(c)) begin
            trail_pending_next = 1'b1;
          end
        end
      end
    end
  end

  assign in_ch.ready = push_ready;
  assign accept = in_ch.valid && push_ready;
  assign push_valid = in_ch.valid && (n != '0);

  assign push_cmd.bytes = bytes;
  assign push_cmd.last_idx = sjse_pkg::RUN_IDX_W'(n - 1'b1);
  assign push_cmd.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      multibyte_enable <= 1'b1;
      quote_open <= 1'b0;
      pending_cr <= 1'b0;
      trail_pending <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        multibyte_enable <= cfg_wr_data;
      end
      if (accept) begin
        quote_open <= quote_open_next;
        pending_cr <= pending_cr_next;
        trail_pending <= trail_pending_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sjse_queue.sv =====
// sjse_queue: two-entry command queue between front and back
// depends on sjse_pkg
`timescale 1ns / 1ps
`default_nettype none

module sjse_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sjse_pkg::cmd_t  push_cmd,
  input  wire logic            push_valid,
  output logic                 push_ready,
  output sjse_pkg::cmd_t       pop_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready
);

  sjse_pkg::cmd_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_cmd = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sjse_back.sv =====
// sjse_back: walks the head command one byte per cycle, while out_ch is not stalling, into the output register
// depends on sjse_pkg and sjse_out_if
`timescale 1ns / 1ps
`default_nettype none

module sjse_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sjse_pkg::cmd_t  pop_cmd,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  sjse_out_if.source           out_ch
);

  logic [sjse_pkg::RUN_IDX_W-1:0] idx;
  logic                           out_valid;
  logic [7:0]                     out_byte;
  logic                           last_in_run;
  logic                           literal_done;
  logic                           load;
  logic                           at_last;

  assign load = pop_valid && (!out_valid || out_ch.ready);
  assign at_last = (idx == pop_cmd.last_idx);
  assign pop_ready = load && at_last;

  assign out_ch.valid = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last_in_run = last_in_run;
  assign out_ch.literal_done = literal_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= at_last ? '0 : idx + 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= pop_cmd.bytes[idx];
      last_in_run <= at_last;
      literal_done <= at_last && pop_cmd.done;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shiftjis_string_literal_escaper_top.sv =====
// shiftjis_string_literal_escaper_top: front classifier, command queue and byte serializer
// depends on sjse_pkg, sjse_in_if, sjse_out_if, sjse_front, sjse_queue, sjse_back
//
// channel   dir   handshake      payload
// in_ch     in    valid/ready    char_byte[7:0], end_of_string
// out_ch    out   valid/ready    out_byte[7:0], last_in_run, literal_done
// cfg       in    cfg_wr_en      cfg_wr_data (multibyte_enable)
//
// an item is taken whenever the two-entry queue has room
// each item gives 0 to 4 output bytes, sent from the output register one per cycle
// while out_ch does not stall; the queue takes new items while earlier ones drain
// the first output byte goes through a queue entry, then the output register
// rst is synchronous; out_ch stalls back up through the queue into in_ch.ready
`timescale 1ns / 1ps
`default_nettype none

module shiftjis_string_literal_escaper_top (
  input  wire logic  clk,
  input  wire logic  rst,
  sjse_in_if.sink    in_ch,
  sjse_out_if.source out_ch,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);

  sjse_pkg::cmd_t push_cmd;
  logic           push_valid;
  logic           push_ready;
  sjse_pkg::cmd_t pop_cmd;
  logic           pop_valid;
  logic           pop_ready;

  sjse_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push_cmd    (push_cmd),
    .push_valid  (push_valid),
    .push_ready  (push_ready)
  );

  sjse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  sjse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.literal_done |-> out_ch.last_in_run)
    else $error("literal_done without last_in_run");

  a_done_is_quote: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.literal_done |-> out_ch.out_byte == sjse_pkg::CH_QUOTE)
    else $error("closing byte is not a quote");

  a_push_done_quote: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_cmd.done |-> push_cmd.bytes[push_cmd.last_idx] == sjse_pkg::CH_QUOTE)
    else $error("terminator command does not end in a quote");

  a_pop_then_load: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready |=> out_ch.valid && out_ch.last_in_run)
    else $error("popped command did not end in a last byte");

endmodule

`default_nettype wire

// ===== tb/sv/sjse_checker.sv =====
// sjse_checker: watches the in/out channels and config port of the escaper and
// predicts the quoted literal bytes, comparing each output item in order
// depends on sjse_pkg, sjse_in_if, sjse_out_if
`timescale 1ns / 1ps

module sjse_checker (
  input  logic clk,
  input  logic rst,
  sjse_in_if   in_ch,
  sjse_out_if  out_ch,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output int   fail_count,
  output int   pending,
  output int   n_items,
  output int   n_bytes,
  output int   n_literals
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } lit_byte_t;

  lit_byte_t lit_q[$];
  logic      mb_en;
  logic      quote_open;
  logic      cr_held;
  logic      trail_due;

  function automatic void add_byte(input logic [7:0] b, input logic done);
    lit_q.push_back('{data: b, last: 1'b0, done: done});
  endfunction

  function automatic void add_escape(input logic [7:0] b);
    add_byte(sjse_pkg::CH_BSLASH, 1'b0);
    add_byte(b, 1'b0);
  endfunction

  // expected output bytes for one source item
  function automatic void escape_item(input logic [7:0] c, input logic eos);
    int        first;
    lit_byte_t tail;
    first = lit_q.size();
    if (!quote_open) begin
      add_byte(sjse_pkg::CH_QUOTE, 1'b0);
      quote_open = 1'b1;
    end
    if (eos) begin
      if (cr_held) add_escape(sjse_pkg::CH_LOW_R);
      add_byte(sjse_pkg::CH_QUOTE, 1'b1);
      quote_open = 1'b0;
      cr_held = 1'b0;
      trail_due = 1'b0;
    end else if (trail_due) begin
      add_byte(c, 1'b0);
      trail_due = 1'b0;
    end else if (cr_held && c == sjse_pkg::CH_LF) begin
      add_escape(sjse_pkg::CH_LOW_N);
      cr_held = 1'b0;
    end else begin
      if (cr_held) begin
        add_escape(sjse_pkg::CH_LOW_R);
        cr_held = 1'b0;
      end
      if (c == sjse_pkg::CH_CR) begin
        cr_held = 1'b1;
      end else if (c == sjse_pkg::CH_TAB) begin
        add_escape(sjse_pkg::CH_LOW_T);
      end else if (c == sjse_pkg::CH_QUOTE || c == sjse_pkg::CH_BSLASH) begin
        add_escape(c);
      end else begin
        add_byte(c, 1'b0);
        // sjis lead byte ranges
        if (mb_en && ((c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hFC)))
          trail_due = 1'b1;
      end
    end
    if (lit_q.size() > first) begin
      tail = lit_q.pop_back();
      tail.last = 1'b1;
      lit_q.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    lit_byte_t want;
    if (rst) begin
      mb_en = 1'b1;
      quote_open = 1'b0;
      cr_held = 1'b0;
      trail_due = 1'b0;
      lit_q.delete();
      fail_count = 0;
      n_items = 0;
      n_bytes = 0;
      n_literals = 0;
    end else begin
      if (cfg_wr_en) mb_en = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) begin
        escape_item(in_ch.char_byte, in_ch.end_of_string);
        n_items++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_bytes++;
        if (out_ch.literal_done) n_literals++;
        if (lit_q.size() == 0) begin
          if (fail_count < 10)
            $display("mismatch: unexpected item out_byte %h last %b done %b",
                     out_ch.out_byte, out_ch.last_in_run, out_ch.literal_done);
          fail_count++;
        end else begin
          want = lit_q.pop_front();
          if (want.data !== out_ch.out_byte || want.last !== out_ch.last_in_run ||
              want.done !== out_ch.literal_done) begin
            if (fail_count < 10)
              $display("mismatch: expected byte %h last %b done %b, got byte %h last %b done %b",
                       want.data, want.last, want.done,
                       out_ch.out_byte, out_ch.last_in_run, out_ch.literal_done);
            fail_count++;
          end
        end
      end
    end
    pending = lit_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: drives source strings and config writes into the escaper with random idling
// depends on sjse_pkg, sjse_in_if, sjse_out_if, sjse_checker and the escaper top
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic calm;
  int   fail_count;
  int   pending;
  int   n_items;
  int   n_bytes;
  int   n_literals;
  int   stall_cycles;

  sjse_in_if  in_ch ();
  sjse_out_if out_ch ();

  shiftjis_string_literal_escaper_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  sjse_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_items    (n_items),
    .n_bytes    (n_bytes),
    .n_literals (n_literals)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_source(input logic [7:0] b, input logic eos);
    while (!calm && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      in_ch.char_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_byte <= b;
    in_ch.end_of_string <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a held cr gives no output, so leave room for it to settle
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic mb);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mb;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0: pick_byte = sjse_pkg::CH_TAB;
      1: pick_byte = sjse_pkg::CH_CR;
      2: pick_byte = sjse_pkg::CH_LF;
      3: pick_byte = sjse_pkg::CH_QUOTE;
      4: pick_byte = sjse_pkg::CH_BSLASH;
      5: pick_byte = 8'($urandom_range(8'h9F, 8'h81));
      6: pick_byte = 8'($urandom_range(8'hFC, 8'hE0));
      default: pick_byte = 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int len;
    int sent;
    rst <= 1'b1;
    calm <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.char_byte <= 8'h00;
    in_ch.end_of_string <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings, multibyte on
    write_mode(1'b1);
    push_source(8'h00, 1'b1);
    push_source(sjse_pkg::CH_TAB, 1'b0);
    push_source(sjse_pkg::CH_QUOTE, 1'b0);
    push_source(sjse_pkg::CH_BSLASH, 1'b0);
    push_source(sjse_pkg::CH_CR, 1'b0);
    push_source(sjse_pkg::CH_LF, 1'b0);
    push_source(8'h00, 1'b0);
    push_source(8'hFF, 1'b0);
    push_source(sjse_pkg::CH_CR, 1'b0);
    push_source(sjse_pkg::CH_CR, 1'b0);
    push_source(sjse_pkg::CH_LF, 1'b0);
    push_source(8'hFF, 1'b1);
    push_source(8'h81, 1'b0);
    push_source(sjse_pkg::CH_BSLASH, 1'b0);
    push_source(8'hFC, 1'b0);
    push_source(sjse_pkg::CH_QUOTE, 1'b0);
    push_source(8'hE0, 1'b0);
    push_source(sjse_pkg::CH_TAB, 1'b0);
    push_source(8'h9F, 1'b0);
    push_source(8'h00, 1'b1);
    push_source(sjse_pkg::CH_CR, 1'b0);
    push_source(sjse_pkg::CH_CR, 1'b1);
    wait_idle();

    // multibyte off, then a lead byte that straddles a mode change
    write_mode(1'b0);
    push_source(8'h81, 1'b0);
    push_source(sjse_pkg::CH_BSLASH, 1'b0);
    push_source(8'h00, 1'b1);
    wait_idle();
    write_mode(1'b1);
    push_source(8'h9F, 1'b0);
    wait_idle();
    write_mode(1'b0);
    push_source(sjse_pkg::CH_BSLASH, 1'b0);
    push_source(8'h00, 1'b1);
    wait_idle();

    // random strings, one mode setting per phase, one phase without idling
    for (int ph = 0; ph < 4; ph++) begin
      calm <= (ph == 2);
      write_mode(ph == 1 ? 1'b0 : (ph == 3 ? 1'($urandom_range(1)) : 1'b1));
      sent = 0;
      while (sent < 60) begin
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(12);
        for (int i = 0; i < len; i++) push_source(pick_byte(), 1'b0);
        push_source(8'($urandom_range(255)), 1'b1);
        sent += len + 1;
      end
      wait_idle();
    end

    $display("run covered %0d source items and %0d literal bytes in %0d literals,",
             n_items, n_bytes, n_literals);
    $display("with multibyte handling both on and off and random stalls on both sides");
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
